// ===== rtl/core/sorted_set_insert_array_unit_macros.svh =====
// Assertion macros shared by the sorted set checker.
`ifndef SORTED_SET_INSERT_ARRAY_UNIT_MACROS_SVH
`define SORTED_SET_INSERT_ARRAY_UNIT_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define SSIA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: label");

// Condition must hold in the cycle after the trigger.
`define SSIA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: label");

`endif

// ===== rtl/core/ssia_pkg.sv =====
// Shared constants, codes and types of the sorted set insert unit.
`timescale 1ns / 1ps
package ssia_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int VALUE_W      = 31;
	localparam int STATUS_W     = 3;
	localparam int POS_W        = 6;
	localparam int COUNT_W      = 7;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FULL      = 3'd2,
		ST_RANGE     = 3'd3,
		ST_ELEMENT   = 3'd4,
		ST_EMPTY     = 3'd5
	} status_t;

	// One read and one write on the element store per cycle
	typedef struct packed {
		logic               wr_en;
		logic [COUNT_W-1:0] wr_idx;
		logic [VALUE_W-1:0] wr_data;
		logic               rd_en;
		logic [COUNT_W-1:0] rd_idx;
	} store_req_t;

endpackage

// ===== rtl/core/ssia_store.sv =====
// Element store: one write port and one registered read port.
`timescale 1ns / 1ps
module ssia_store #(
	parameter int DEPTH = ssia_pkg::CAPACITY_DEF
) (
	input  logic                         clk,
	input  ssia_pkg::store_req_t         req,
	output logic [ssia_pkg::VALUE_W-1:0] rdata
);
	import ssia_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [VALUE_W-1:0] mem [DEPTH];
	logic [VALUE_W-1:0] rdata_q;

	// Write the addressed entry
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_idx[AW-1:0]] <= req.wr_data;
		end
	end

	// Register read data; hold it while no read is requested
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rdata_q <= mem[req.rd_idx[AW-1:0]];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/sorted_set_insert_array_unit.sv =====
// Top level of the sorted set insert unit: sequencer, shared comparator, output register.
//
// Keeps up to CAPACITY distinct values in ascending order in a single-port-read store.
// Input stream: s_tuser = action (0 insert, 1 report), s_tdata[30:0] = value.
// Output stream: s_tdata-style packing on m_tdata = {count, position, element, status},
// m_tlast marks the final result of a request.
// cfg_wr_en/cfg_wr_data write the sentinel limit (exclusive upper bound of inserts);
// write it only while the unit is idle.
// An insert walks the store one entry per cycle through one comparator until it finds
// the first entry not below the value, then moves the larger entries up one place per
// cycle (one read and one write port), then writes the value; one result per insert.
// A report reads one entry, hands it out, then reads the next, and gives n results, or one empty result.
// One request is in work at a time; s_tready is high only while the sequencer is idle,
// and a new request is taken while the last result still waits in the output register.
// If the receiver stalls, the result is held in the output register and the sequencer
// waits before it loads the next result.
// Reset clears the count and the output valid and sets the limit to its maximum;
// the store itself is not cleared, entries at or above the count are never read.
`timescale 1ns / 1ps
module sorted_set_insert_array_unit #(
	parameter int CAPACITY = ssia_pkg::CAPACITY_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [ssia_pkg::VALUE_W-1:0] cfg_wr_data, // sentinel_limit
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [31:0]                  s_tdata,     // value[30:0], zero pad
	input  logic                         s_tuser,     // action
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [47:0]                  m_tdata,     // status[2:0], element[33:3],
	                                                  // position[39:34], count[46:40], pad
	output logic                         m_tlast      // last
);
	import ssia_pkg::*;

	localparam logic [COUNT_W-1:0] CAP_N = COUNT_W'(CAPACITY);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_SCAN   = 8'b0000_0010,
		S_DECIDE = 8'b0000_0100,
		S_SHIFT  = 8'b0000_1000,
		S_WRITE  = 8'b0001_0000,
		S_EMIT   = 8'b0010_0000,
		S_RPT_RD = 8'b0100_0000,
		S_RPT_OUT= 8'b1000_0000
	} state_t;

	state_t             state_q;
	logic [VALUE_W-1:0] limit_q;
	logic [VALUE_W-1:0] val_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] scan_q;
	logic [COUNT_W-1:0] pidx_q;
	logic [COUNT_W-1:0] pos_q;
	logic [COUNT_W-1:0] sh_q;
	logic               pend_q;
	logic               eq_q;
	logic               more_q;
	status_t            res_status_q;
	logic [POS_W-1:0]   res_pos_q;
	logic [COUNT_W-1:0] res_count_q;
	logic               out_valid_q;
	status_t            out_status_q;
	logic [VALUE_W-1:0] out_elem_q;
	logic [POS_W-1:0]   out_pos_q;
	logic [COUNT_W-1:0] out_count_q;
	logic               out_last_q;

	logic [VALUE_W-1:0] s_value;
	logic [VALUE_W-1:0] rdata;
	logic [VALUE_W-1:0] cmp_a;
	logic [VALUE_W-1:0] cmp_b;
	logic               cmp_lt;
	logic               cmp_eq;
	logic               out_free;
	logic               out_load;
	logic               scan_hit;
	store_req_t         req;

	assign s_value  = s_tdata[VALUE_W-1:0];
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || m_tready;
	assign out_load = out_free && ((state_q == S_EMIT) || (state_q == S_RPT_OUT));

	// Shared comparator: range check on accept, store entry against value while scanning
	always_comb begin
		if (state_q == S_SCAN) begin
			cmp_a = rdata;
			cmp_b = val_q;
		end else begin
			cmp_a = s_value;
			cmp_b = limit_q;
		end
	end
	assign cmp_lt   = (cmp_a < cmp_b);
	assign cmp_eq   = (cmp_a == cmp_b);
	assign scan_hit = pend_q && !cmp_lt;

	// Store access per state
	always_comb begin
		req = '0;
		unique case (state_q)
			S_SCAN: begin
				req.rd_en  = !scan_hit && (scan_q != count_q);
				req.rd_idx = scan_q;
			end
			S_SHIFT: begin
				req.rd_en   = more_q;
				req.rd_idx  = sh_q;
				req.wr_en   = pend_q;
				req.wr_idx  = pidx_q + COUNT_W'(1);
				req.wr_data = rdata;
			end
			S_WRITE: begin
				req.wr_en   = 1'b1;
				req.wr_idx  = pos_q;
				req.wr_data = val_q;
			end
			S_RPT_RD: begin
				req.rd_en  = 1'b1;
				req.rd_idx = scan_q;
			end
			S_IDLE, S_DECIDE, S_EMIT, S_RPT_OUT: begin
				req = '0;
			end
			default: begin
				req = '0;
			end
		endcase
	end

	ssia_store #(
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.req  (req),
		.rdata(rdata)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			limit_q      <= '1;
			val_q        <= '0;
			count_q      <= '0;
			scan_q       <= '0;
			pidx_q       <= '0;
			pos_q        <= '0;
			sh_q         <= '0;
			pend_q       <= 1'b0;
			eq_q         <= 1'b0;
			more_q       <= 1'b0;
			res_status_q <= ST_INSERTED;
			res_pos_q    <= '0;
			res_count_q  <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_INSERTED;
			out_elem_q   <= '0;
			out_pos_q    <= '0;
			out_count_q  <= '0;
			out_last_q   <= 1'b0;
		end else begin
			// Load the sentinel limit
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			// Load a new result, or drop the output once taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						val_q  <= s_value;
						scan_q <= '0;
						pend_q <= 1'b0;
						if (s_tuser) begin
							if (count_q == '0) begin
								res_status_q <= ST_EMPTY;
								res_pos_q    <= '0;
								res_count_q  <= '0;
								state_q      <= S_EMIT;
							end else begin
								state_q <= S_RPT_RD;
							end
						end else if (!cmp_lt) begin
							res_status_q <= ST_RANGE;
							res_pos_q    <= '0;
							res_count_q  <= count_q;
							state_q      <= S_EMIT;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// Stop at the first entry not below the value, or past the end
					if (scan_hit) begin
						pos_q   <= pidx_q;
						eq_q    <= cmp_eq;
						pend_q  <= 1'b0;
						state_q <= S_DECIDE;
					end else if (scan_q == count_q) begin
						pos_q   <= count_q;
						eq_q    <= 1'b0;
						pend_q  <= 1'b0;
						state_q <= S_DECIDE;
					end else begin
						pend_q <= 1'b1;
						pidx_q <= scan_q;
						scan_q <= scan_q + COUNT_W'(1);
					end
				end
				S_DECIDE: begin
					if (eq_q) begin
						res_status_q <= ST_DUPLICATE;
						res_pos_q    <= pos_q[POS_W-1:0];
						res_count_q  <= count_q;
						state_q      <= S_EMIT;
					end else if (count_q == CAP_N) begin
						res_status_q <= ST_FULL;
						res_pos_q    <= '0;
						res_count_q  <= count_q;
						state_q      <= S_EMIT;
					end else if (count_q == pos_q) begin
						state_q <= S_WRITE;
					end else begin
						sh_q    <= count_q - COUNT_W'(1);
						more_q  <= 1'b1;
						pend_q  <= 1'b0;
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					// Read entry k while the entry read before lands one place up
					if (more_q) begin
						pend_q <= 1'b1;
						pidx_q <= sh_q;
						if (sh_q == pos_q) begin
							more_q <= 1'b0;
						end else begin
							sh_q <= sh_q - COUNT_W'(1);
						end
					end else begin
						pend_q  <= 1'b0;
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					count_q      <= count_q + COUNT_W'(1);
					res_status_q <= ST_INSERTED;
					res_pos_q    <= pos_q[POS_W-1:0];
					res_count_q  <= count_q + COUNT_W'(1);
					state_q      <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						out_status_q <= res_status_q;
						out_elem_q   <= '0;
						out_pos_q    <= res_pos_q;
						out_count_q  <= res_count_q;
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				S_RPT_RD: begin
					state_q <= S_RPT_OUT;
				end
				S_RPT_OUT: begin
					// Hand out one element; advance or finish
					if (out_free) begin
						out_status_q <= ST_ELEMENT;
						out_elem_q   <= rdata;
						out_pos_q    <= scan_q[POS_W-1:0];
						out_count_q  <= count_q;
						out_last_q   <= (scan_q + COUNT_W'(1) == count_q);
						if (scan_q + COUNT_W'(1) == count_q) begin
							state_q <= S_IDLE;
						end else begin
							scan_q  <= scan_q + COUNT_W'(1);
							state_q <= S_RPT_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {1'b0, out_count_q, out_pos_q, out_elem_q, out_status_q};

endmodule

// ===== rtl/core/ssia_checker.sv =====
// Port-level checker for the sorted set insert unit, with its bind.
`timescale 1ns / 1ps
`include "sorted_set_insert_array_unit_macros.svh"
module ssia_checker #(
	parameter int CAPACITY = ssia_pkg::CAPACITY_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         cfg_wr_en,
	input logic [ssia_pkg::VALUE_W-1:0] cfg_wr_data,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic [31:0]                  s_tdata,
	input logic                         s_tuser,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [47:0]                  m_tdata,
	input logic                         m_tlast
);
	import ssia_pkg::*;

	logic [STATUS_W-1:0] o_status;
	logic [VALUE_W-1:0]  o_elem;
	logic [POS_W-1:0]    o_pos;
	logic [COUNT_W-1:0]  o_count;

	assign o_status = m_tdata[2:0];
	assign o_elem   = m_tdata[33:3];
	assign o_pos    = m_tdata[39:34];
	assign o_count  = m_tdata[46:40];

	// A stalled result holds
	`SSIA_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tlast))

	// Every result but a report element ends its request
	`SSIA_ASSERT_NOW(a_single_last, clk, arst_n,
		m_tvalid && (o_status != ST_ELEMENT), m_tlast)

	// The count never passes the capacity
	`SSIA_ASSERT_NOW(a_count_cap, clk, arst_n, m_tvalid,
		o_count <= COUNT_W'(CAPACITY))

	// A reported element lies inside the set; the last one closes it
	`SSIA_ASSERT_NOW(a_elem_pos, clk, arst_n, m_tvalid && (o_status == ST_ELEMENT),
		(COUNT_W'(o_pos) < o_count) && (m_tlast == (COUNT_W'(o_pos) + 7'd1 == o_count)))

	// An empty report carries no element and no count
	`SSIA_ASSERT_NOW(a_empty_zero, clk, arst_n, m_tvalid && (o_status == ST_EMPTY),
		(o_count == '0) && (o_elem == '0) && (o_pos == '0))

endmodule

bind sorted_set_insert_array_unit ssia_checker #(.CAPACITY(CAPACITY)) u_ssia_checker (.*);

// ===== test/tb_sorted_set_insert_array_unit.sv =====
// Testbench for the sorted set insert unit: directed and random requests against a predictor.
`timescale 1ns / 1ps
module tb_sorted_set_insert_array_unit;
	import ssia_pkg::*;

	localparam int SET_CAPACITY = CAPACITY_DEF;
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REPORT = 1'b1;
	localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};
	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		status_t              status;
		logic [VALUE_W-1:0]   element;
		logic [POS_W-1:0]     position;
		logic [COUNT_W-1:0]   count;
		logic                 last;
	} set_result_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [VALUE_W-1:0]  cfg_wr_data;
	logic                s_tvalid;
	logic                s_tready;
	logic [31:0]         s_tdata;     // value[30:0], zero pad
	logic                s_tuser;     // action
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [47:0]         m_tdata;     // status[2:0], element[33:3], position[39:34], count[46:40]
	logic                m_tlast;     // last

	// Predicted contents of the set and the current limit
	logic [VALUE_W-1:0]  model_set [SET_CAPACITY];
	int                  model_size;
	logic [VALUE_W-1:0]  model_limit;
	set_result_t         awaited_results[$];

	int src_idle_pct;
	int snk_idle_pct;
	int error_count;
	int inserts_sent;
	int reports_sent;
	int results_checked;
	int limit_writes;
	int stall_cycles;

	sorted_set_insert_array_unit #(
		.CAPACITY(SET_CAPACITY)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	// 50 MHz clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic void push_result(status_t st, logic [VALUE_W-1:0] elem, int pos, int cnt,
			logic lst);
		set_result_t r;
		r.status = st;
		r.element = elem;
		r.position = POS_W'(pos);
		r.count = COUNT_W'(cnt);
		r.last = lst;
		awaited_results.push_back(r);
	endfunction

	function automatic bit set_holds(logic [VALUE_W-1:0] val);
		for (int k = 0; k < model_size; k++)
			if (model_set[k] == val)
				return 1'b1;
		return 1'b0;
	endfunction

	// Compute the results of one request and update the predicted set
	function automatic void predict_request(logic act, logic [VALUE_W-1:0] val);
		int slot;
		if (act == ACT_REPORT) begin
			if (model_size == 0)
				push_result(ST_EMPTY, '0, 0, 0, 1'b1);
			for (int k = 0; k < model_size; k++)
				push_result(ST_ELEMENT, model_set[k], k, model_size, k + 1 == model_size);
			return;
		end
		if (val >= model_limit) begin
			push_result(ST_RANGE, '0, 0, model_size, 1'b1);
			return;
		end
		slot = 0;
		while (slot < model_size && model_set[slot] < val)
			slot++;
		if (slot < model_size && model_set[slot] == val) begin
			push_result(ST_DUPLICATE, '0, slot, model_size, 1'b1);
			return;
		end
		if (model_size >= SET_CAPACITY) begin
			push_result(ST_FULL, '0, 0, model_size, 1'b1);
			return;
		end
		for (int k = model_size; k > slot; k--)
			model_set[k] = model_set[k - 1];
		model_set[slot] = val;
		model_size++;
		push_result(ST_INSERTED, '0, slot, model_size, 1'b1);
	endfunction

	function automatic void field_mismatch(string field, longint unsigned want,
			longint unsigned got);
		$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
		error_count++;
	endfunction

	// Compare one result with the oldest prediction
	function automatic void check_result(logic [47:0] data, logic lst);
		set_result_t got;
		set_result_t want;
		got.status = status_t'(data[2:0]);
		got.element = data[33:3];
		got.position = data[39:34];
		got.count = data[46:40];
		got.last = lst;
		if (awaited_results.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual status %0d element 0x%0h",
				$time, got.status, got.element);
			error_count++;
			return;
		end
		want = awaited_results.pop_front();
		results_checked++;
		if (got.status !== want.status)
			field_mismatch("status", want.status, got.status);
		if (got.element !== want.element)
			field_mismatch("element", want.element, got.element);
		if (got.position !== want.position)
			field_mismatch("position", want.position, got.position);
		if (got.count !== want.count)
			field_mismatch("count", want.count, got.count);
		if (got.last !== want.last)
			field_mismatch("last", want.last, got.last);
	endfunction

	// Take results and stall at random
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_result(m_tdata, m_tlast);
		m_tready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// Abort when no handshake happens for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: watchdog expired, %0d results still awaited", $time,
				awaited_results.size());
			$display("Regression FAIL");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Offer one request, with random idle cycles ahead of it
	task automatic send_request(input logic act, input logic [VALUE_W-1:0] val);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {1'b0, val};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_request(act, val);
		if (act == ACT_REPORT)
			reports_sent++;
		else
			inserts_sent++;
	endtask

	// Hold the input until every result is back and the unit is ready again
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic write_limit(input logic [VALUE_W-1:0] lim);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= lim;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		model_limit = lim;
		limit_writes++;
	endtask

	function automatic logic [VALUE_W-1:0] fresh_value();
		logic [VALUE_W-1:0] v;
		do
			v = VALUE_W'($urandom());
		while (v >= model_limit || set_holds(v));
		return v;
	endfunction

	function automatic logic [VALUE_W-1:0] above_limit();
		if (model_limit == VALUE_MAX)
			return VALUE_MAX;
		return VALUE_W'($urandom_range(32'(VALUE_MAX), 32'(model_limit)));
	endfunction

	task automatic test_empty_report();
		send_request(ACT_REPORT, VALUE_W'($urandom()));
	endtask

	// Extremes of the value field at the reset limit, duplicates at both ends
	task automatic test_insert_extremes();
		send_request(ACT_INSERT, VALUE_MAX);
		send_request(ACT_INSERT, VALUE_MAX - 1);
		send_request(ACT_INSERT, '0);
		send_request(ACT_INSERT, '0);
		send_request(ACT_INSERT, VALUE_MAX - 1);
		send_request(ACT_INSERT, 31'h2AAA_AAAA);
		send_request(ACT_INSERT, 31'h5555_5555);
		send_request(ACT_INSERT, 31'h0000_0001);
		send_request(ACT_INSERT, 31'h2AAA_AAAA);
		send_request(ACT_REPORT, VALUE_MAX);
	endtask

	// Lowered limit: old entries stay, everything at or above the limit is refused
	task automatic test_lowered_limit();
		write_limit('0);
		send_request(ACT_INSERT, '0);
		send_request(ACT_INSERT, 31'd5);
		send_request(ACT_REPORT, '0);
		write_limit(31'h100);
		send_request(ACT_INSERT, 31'h5555_5555);
		send_request(ACT_INSERT, 31'hFF);
		send_request(ACT_INSERT, 31'h100);
		send_request(ACT_INSERT, 31'h1);
		send_request(ACT_REPORT, '0);
		wait_idle();
	endtask

	// Mostly inserts: duplicates, small values, refused values, full-range values
	task automatic test_random_requests(input int num);
		int pick;
		for (int n = 0; n < num; n++) begin
			pick = $urandom_range(99);
			if (pick < 10)
				send_request(ACT_REPORT, VALUE_W'($urandom()));
			else if (pick < 30 && model_size > 0)
				send_request(ACT_INSERT, model_set[$urandom_range(model_size - 1)]);
			else if (pick < 45)
				send_request(ACT_INSERT, VALUE_W'($urandom_range(255)));
			else if (pick < 55)
				send_request(ACT_INSERT, above_limit());
			else
				send_request(ACT_INSERT, VALUE_W'($urandom()));
			// drain now and then so a new request meets an empty output path
			if ($urandom_range(99) < 3)
				wait_idle();
		end
	endtask

	// Fill the set, then hit the full store with new, held and refused values
	task automatic test_full_store();
		while (model_size < SET_CAPACITY)
			send_request(ACT_INSERT, fresh_value());
		send_request(ACT_INSERT, fresh_value());
		send_request(ACT_INSERT, model_set[0]);
		send_request(ACT_INSERT, model_set[SET_CAPACITY - 1]);
		send_request(ACT_INSERT, model_set[$urandom_range(SET_CAPACITY - 1)]);
		send_request(ACT_INSERT, VALUE_MAX);
		send_request(ACT_REPORT, VALUE_W'($urandom()));
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= ACT_INSERT;
		model_size = 0;
		model_limit = VALUE_MAX;
		src_idle_pct = 38;
		snk_idle_pct = 52;
		error_count = 0;
		inserts_sent = 0;
		reports_sent = 0;
		results_checked = 0;
		limit_writes = 0;
		stall_cycles = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender sparse, receiver slow
		test_empty_report();
		test_insert_extremes();
		test_lowered_limit();
		write_limit(VALUE_W'($urandom_range(32'h7FFF_FFFF, 32'h1000)));
		test_random_requests(80);

		// sender slow, receiver sparse
		src_idle_pct = 52;
		snk_idle_pct = 38;
		write_limit(VALUE_W'($urandom_range(32'h7FFF_FFFF, 32'h0100_0000)));
		test_random_requests(80);

		// no idling at all
		src_idle_pct = 0;
		snk_idle_pct = 0;
		write_limit(VALUE_MAX);
		test_full_store();
		test_random_requests(80);

		wait_idle();
		$display("Sent %0d inserts and %0d reports under %0d limit settings;",
			inserts_sent, reports_sent, limit_writes);
		$display("checked %0d results, set held %0d of %0d entries at the end.",
			results_checked, model_size, SET_CAPACITY);
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
